>>> hdl/e2q_pkg.sv
// Shared types and constants for the Euler-angle to quaternion converter.
`default_nettype none

package e2q_pkg;

  localparam int ANGLE_WIDTH   = 16;
  localparam int OUT_FRAC_BITS = 14;
  localparam int OUT_WIDTH     = OUT_FRAC_BITS + 2;

  // internal sine/cosine and product format, Q2.30
  localparam int WORK_W    = 32;
  localparam int WORK_FRAC = 30;

  localparam int CORDIC_STEPS = 30;
  // CORDIC stages, two multiply stages, sum stage, output stage
  localparam int LATENCY      = CORDIC_STEPS + 4;

  typedef logic signed [WORK_W-1:0] work_t;

  localparam work_t CORDIC_GAIN = 32'sd652032874;

  // atan(2^-i) in units of 2^-32 turn
  localparam work_t ATAN_TURNS [CORDIC_STEPS] = '{
    32'h20000000, 32'h12E4051E, 32'h09FB385B, 32'h051111D4, 32'h028B0D43,
    32'h0145D7E1, 32'h00A2F61E, 32'h00517C55, 32'h0028BE53, 32'h00145F2F,
    32'h000A2F98, 32'h000517CC, 32'h00028BE6, 32'h000145F3, 32'h0000A2FA,
    32'h0000517D, 32'h000028BE, 32'h0000145F, 32'h00000A30, 32'h00000518,
    32'h0000028C, 32'h00000146, 32'h000000A3, 32'h00000051, 32'h00000029,
    32'h00000014, 32'h0000000A, 32'h00000005, 32'h00000003, 32'h00000001
  };

  typedef struct packed {
    logic signed [ANGLE_WIDTH-1:0] roll_angle;
    logic signed [ANGLE_WIDTH-1:0] pitch_angle;
    logic signed [ANGLE_WIDTH-1:0] yaw_angle;
  } in_t;

  typedef struct packed {
    logic signed [OUT_WIDTH-1:0] q_w;
    logic signed [OUT_WIDTH-1:0] q_x;
    logic signed [OUT_WIDTH-1:0] q_y;
    logic signed [OUT_WIDTH-1:0] q_z;
  } out_t;

  typedef struct packed {
    work_t sin_v;
    work_t cos_v;
  } sc_t;

endpackage

`default_nettype wire

>>> hdl/e2q_cordic.sv
// Pipelined rotation-mode CORDIC: sine and cosine of half a binary angle.
`default_nettype none

module e2q_cordic (
  input  wire logic                                   clk,
  input  wire logic                                   en,
  input  wire logic signed [e2q_pkg::ANGLE_WIDTH-1:0] angle,
  output e2q_pkg::sc_t                                sc
);
  import e2q_pkg::*;

  work_t x_r [CORDIC_STEPS];
  work_t y_r [CORDIC_STEPS];
  work_t z_r [CORDIC_STEPS];

  work_t turn;
  work_t half;

  // left-align into a full-turn count, then halve
  assign turn = WORK_W'(angle) <<< (WORK_W - ANGLE_WIDTH);
  assign half = turn >>> 1;

  for (genvar k = 0; k < CORDIC_STEPS; k++) begin : g_step
    work_t xi;
    work_t yi;
    work_t zi;

    if (k == 0) begin : g_first
      assign xi = CORDIC_GAIN;
      assign yi = '0;
      assign zi = half;
    end else begin : g_next
      assign xi = x_r[k-1];
      assign yi = y_r[k-1];
      assign zi = z_r[k-1];
    end

    always_ff @(posedge clk) begin
      if (en) begin
        if (!zi[WORK_W-1]) begin
          x_r[k] <= xi - (yi >>> k);
          y_r[k] <= yi + (xi >>> k);
          z_r[k] <= zi - ATAN_TURNS[k];
        end else begin
          x_r[k] <= xi + (yi >>> k);
          y_r[k] <= yi - (xi >>> k);
          z_r[k] <= zi + ATAN_TURNS[k];
        end
      end
    end
  end

  assign sc.sin_v = y_r[CORDIC_STEPS-1];
  assign sc.cos_v = x_r[CORDIC_STEPS-1];

endmodule

`default_nettype wire

>>> hdl/e2q_quat.sv
// Quaternion assembly: two product stages, a sum stage, round and saturate.
`default_nettype none

module e2q_quat (
  input  wire logic          clk,
  input  wire logic          en,
  input  wire e2q_pkg::sc_t  roll,
  input  wire e2q_pkg::sc_t  pitch,
  input  wire e2q_pkg::sc_t  yaw,
  output e2q_pkg::out_t      q
);
  import e2q_pkg::*;

  localparam int RND_SH = WORK_FRAC - OUT_FRAC_BITS;
  localparam logic signed [WORK_W+1:0] RND_HALF = ((WORK_W+2)'(1) <<< RND_SH) >>> 1;
  localparam logic signed [WORK_W+1:0] Q_ONE    = (WORK_W+2)'(1) <<< OUT_FRAC_BITS;

  typedef logic signed [WORK_W:0] sum_t;

  // Q2.30 multiply, round half up
  function automatic work_t qmul(input work_t a, input work_t b);
    logic signed [2*WORK_W-1:0] p;
    p = a * b + ((2*WORK_W)'(1) <<< (WORK_FRAC - 1));
    return p[WORK_FRAC+WORK_W-1:WORK_FRAC];
  endfunction

  function automatic logic signed [OUT_WIDTH-1:0] finish(input sum_t v);
    logic signed [WORK_W+1:0] t;
    logic signed [WORK_W+1:0] r;
    t = (WORK_W+2)'(v) + RND_HALF;
    r = t >>> RND_SH;
    if (r > Q_ONE) begin
      r = Q_ONE;
    end else if (r < -Q_ONE) begin
      r = -Q_ONE;
    end
    return r[OUT_WIDTH-1:0];
  endfunction

  // roll x pitch partial products, yaw delayed alongside
  work_t cc_r, ss_r, sc_r, cs_r;
  sc_t   yaw_r;

  always_ff @(posedge clk) begin
    if (en) begin
      cc_r  <= qmul(roll.cos_v, pitch.cos_v);
      ss_r  <= qmul(roll.sin_v, pitch.sin_v);
      sc_r  <= qmul(roll.sin_v, pitch.cos_v);
      cs_r  <= qmul(roll.cos_v, pitch.sin_v);
      yaw_r <= yaw;
    end
  end

  // triple products
  work_t ccc_r, sss_r, scc_r, css_r, csc_r, scs_r, ccs_r, ssc_r;

  always_ff @(posedge clk) begin
    if (en) begin
      ccc_r <= qmul(cc_r, yaw_r.cos_v);
      sss_r <= qmul(ss_r, yaw_r.sin_v);
      scc_r <= qmul(sc_r, yaw_r.cos_v);
      css_r <= qmul(cs_r, yaw_r.sin_v);
      csc_r <= qmul(cs_r, yaw_r.cos_v);
      scs_r <= qmul(sc_r, yaw_r.sin_v);
      ccs_r <= qmul(cc_r, yaw_r.sin_v);
      ssc_r <= qmul(ss_r, yaw_r.cos_v);
    end
  end

  sum_t w_r, x_r, y_r, z_r;

  always_ff @(posedge clk) begin
    if (en) begin
      w_r <= (WORK_W+1)'(ccc_r) + (WORK_W+1)'(sss_r);
      x_r <= (WORK_W+1)'(scc_r) - (WORK_W+1)'(css_r);
      y_r <= (WORK_W+1)'(csc_r) + (WORK_W+1)'(scs_r);
      z_r <= (WORK_W+1)'(ccs_r) - (WORK_W+1)'(ssc_r);
    end
  end

  out_t q_r;

  always_ff @(posedge clk) begin
    if (en) begin
      q_r.q_w <= finish(w_r);
      q_r.q_x <= finish(x_r);
      q_r.q_y <= finish(y_r);
      q_r.q_z <= finish(z_r);
    end
  end

  assign q = q_r;

endmodule

`default_nettype wire

>>> hdl/euler_to_quaternion.sv
// An accepted input beat passes through 30 CORDIC stages, two multiply stages,
// a sum stage and the round/saturate stage on its way to its result beat.
// Throughput: one beat per cycle. A stalled result freezes every stage at once,
// so the input stalls only while the output register holds a stalled beat.
// Reset (synchronous, active low) clears the valid bits; data registers keep junk.
`default_nettype none

module euler_to_quaternion (
  input  wire logic     clk,
  input  wire logic     rst_n,
  input  wire logic     in_valid,
  output logic          in_stall,
  input  wire e2q_pkg::in_t in_data,
  output logic          out_valid,
  input  wire logic     out_stall,
  output e2q_pkg::out_t out_data
);
  import e2q_pkg::*;

  logic               en;
  logic [LATENCY-1:0] vld_r;
  logic [LATENCY-1:0] vld_nxt;
  sc_t                roll_sc, pitch_sc, yaw_sc;

  assign en        = !(vld_r[LATENCY-1] && out_stall);
  assign in_stall  = !en;
  assign out_valid = vld_r[LATENCY-1];

  always_comb begin
    vld_nxt = vld_r;
    if (en) begin
      vld_nxt = {vld_r[LATENCY-2:0], in_valid};
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else begin
      vld_r <= vld_nxt;
    end
  end

  e2q_cordic u_roll (
    .clk   (clk),
    .en    (en),
    .angle (in_data.roll_angle),
    .sc    (roll_sc)
  );

  e2q_cordic u_pitch (
    .clk   (clk),
    .en    (en),
    .angle (in_data.pitch_angle),
    .sc    (pitch_sc)
  );

  e2q_cordic u_yaw (
    .clk   (clk),
    .en    (en),
    .angle (in_data.yaw_angle),
    .sc    (yaw_sc)
  );

  e2q_quat u_quat (
    .clk   (clk),
    .en    (en),
    .roll  (roll_sc),
    .pitch (pitch_sc),
    .yaw   (yaw_sc),
    .q     (out_data)
  );

endmodule

`default_nettype wire

>>> hdl/e2q_checker.sv
// Port-level checks for the converter, bound to the top level.
`default_nettype none

module e2q_checker (
  input wire logic     clk,
  input wire logic     rst_n,
  input wire logic     in_valid,
  input wire logic     in_stall,
  input wire e2q_pkg::in_t  in_data,
  input wire logic     out_valid,
  input wire logic     out_stall,
  input wire e2q_pkg::out_t out_data
);
  import e2q_pkg::*;

  localparam logic signed [OUT_WIDTH-1:0] Q_ONE = OUT_WIDTH'(1) <<< OUT_FRAC_BITS;

  // nothing comes out right after reset
  a_reset_empty: assert property (@(posedge clk) !rst_n |=> !out_valid)
    else $error("result beat right after reset");

  // the pipeline only backs up behind a stalled result
  a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
    in_stall |-> (out_valid && out_stall))
    else $error("input stalled without a stalled result");

  a_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_data.q_w <= Q_ONE && out_data.q_w >= -Q_ONE &&
                   out_data.q_x <= Q_ONE && out_data.q_x >= -Q_ONE &&
                   out_data.q_y <= Q_ONE && out_data.q_y >= -Q_ONE &&
                   out_data.q_z <= Q_ONE && out_data.q_z >= -Q_ONE))
    else $error("quaternion component beyond saturation limit");

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_stall) |=> (out_valid && $stable(out_data)))
    else $error("stalled result beat changed");

  a_in_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && in_stall) |=> (in_valid && $stable(in_data)))
    else $error("stalled input beat changed");

endmodule

bind euler_to_quaternion e2q_checker u_e2q_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_valid  (in_valid),
  .in_stall  (in_stall),
  .in_data   (in_data),
  .out_valid (out_valid),
  .out_stall (out_stall),
  .out_data  (out_data)
);

`default_nettype wire

>>> tb/tb_top.sv
// Self-checking testbench for the Euler-angle to quaternion converter.
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  import e2q_pkg::*;

  localparam int  CYCLE_LIMIT  = 600000;
  localparam int  RESET_CYCLES = 11;
  localparam int  N_STEPS      = 30;
  localparam int  FRAC_OUT     = 14;
  localparam longint GAIN_Q30  = 652032874;
  localparam longint ONE_OUT   = 64'sd1 << FRAC_OUT;

  // atan(2^-i) in 2^-32 turn units
  localparam longint ATAN_STEP [N_STEPS] = '{
    'h20000000, 'h12E4051E, 'h09FB385B, 'h051111D4, 'h028B0D43,
    'h0145D7E1, 'h00A2F61E, 'h00517C55, 'h0028BE53, 'h00145F2F,
    'h000A2F98, 'h000517CC, 'h00028BE6, 'h000145F3, 'h0000A2FA,
    'h0000517D, 'h000028BE, 'h0000145F, 'h00000A30, 'h00000518,
    'h0000028C, 'h00000146, 'h000000A3, 'h00000051, 'h00000029,
    'h00000014, 'h0000000A, 'h00000005, 'h00000003, 'h00000001
  };

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_stall;
  in_t  in_data = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  out_t out_data;

  out_t expected_quat_q [$];
  int   mismatch_count = 0;
  int   sent_count = 0;
  int   checked_count = 0;
  int   cycle_count = 0;
  bit   send_gaps_on = 1'b1;
  bit   stall_on = 1'b1;
  int   stall_hold = 0;
  int   stall_roll;

  euler_to_quaternion i_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d results still due",
               cycle_count, expected_quat_q.size());
      $display("euler_to_quaternion: mismatch");
      $finish;
    end
  end

  // ---------------- predictor ----------------

  // sine and cosine of half the binary angle, Q2.30
  function automatic void half_sin_cos(input logic signed [15:0] ang,
                                       output longint s, output longint c);
    logic signed [31:0] turns;
    longint x, y, z, dx, dy;
    turns = {ang, 16'h0000};
    z = turns;
    z = z >>> 1;
    x = GAIN_Q30;
    y = 0;
    for (int i = 0; i < N_STEPS; i++) begin
      dx = y >>> i;
      dy = x >>> i;
      if (z >= 0) begin
        x = x - dx;
        y = y + dy;
        z = z - ATAN_STEP[i];
      end else begin
        x = x + dx;
        y = y - dy;
        z = z + ATAN_STEP[i];
      end
    end
    c = x;
    s = y;
  endfunction

  function automatic longint mul_q30(input longint a, input longint b);
    return (a * b + (64'sd1 << 29)) >>> 30;
  endfunction

  function automatic longint triple_q30(input longint a, input longint b, input longint c);
    return mul_q30(mul_q30(a, b), c);
  endfunction

  function automatic logic signed [15:0] round_saturate(input longint v);
    longint r;
    r = (v + (64'sd1 << (29 - FRAC_OUT))) >>> (30 - FRAC_OUT);
    if (r > ONE_OUT) r = ONE_OUT;
    if (r < -ONE_OUT) r = -ONE_OUT;
    return r[15:0];
  endfunction

  function automatic out_t predict_quat(input in_t angles);
    longint sr, cr, sp, cp, sy, cy;
    out_t q;
    half_sin_cos(angles.roll_angle, sr, cr);
    half_sin_cos(angles.pitch_angle, sp, cp);
    half_sin_cos(angles.yaw_angle, sy, cy);
    q.q_w = round_saturate(triple_q30(cr, cp, cy) + triple_q30(sr, sp, sy));
    q.q_x = round_saturate(triple_q30(sr, cp, cy) - triple_q30(cr, sp, sy));
    q.q_y = round_saturate(triple_q30(cr, sp, cy) + triple_q30(sr, cp, sy));
    q.q_z = round_saturate(triple_q30(cr, cp, sy) - triple_q30(sr, sp, cy));
    return q;
  endfunction

  // ---------------- checking ----------------

  task automatic report_mismatch(input string msg);
    $display("[%0t] ERROR: %s", $realtime, msg);
    mismatch_count++;
  endtask

  task automatic check_component(input string name, input logic signed [15:0] got,
                                 input logic signed [15:0] want);
    if (got !== want)
      report_mismatch($sformatf("result %0d %s: got %0d, expected %0d",
                                checked_count, name, got, want));
  endtask

  always @(posedge clk) begin
    out_t want;
    if (rst_n && out_valid && !out_stall) begin
      if (expected_quat_q.size() == 0) begin
        report_mismatch("result beat with nothing expected");
      end else begin
        want = expected_quat_q.pop_front();
        check_component("q_w", out_data.q_w, want.q_w);
        check_component("q_x", out_data.q_x, want.q_x);
        check_component("q_y", out_data.q_y, want.q_y);
        check_component("q_z", out_data.q_z, want.q_z);
        checked_count++;
      end
    end
  end

  // receiver backpressure: mostly short runs, now and then a long stall
  always @(posedge clk) begin
    if (!stall_on) begin
      out_stall  <= 1'b0;
      stall_hold <= 0;
    end else if (stall_hold > 0) begin
      stall_hold <= stall_hold - 1;
    end else begin
      stall_roll = $urandom_range(0, 99);
      if (stall_roll < 60) begin
        out_stall  <= 1'b0;
        stall_hold <= $urandom_range(0, 6);
      end else if (stall_roll < 92) begin
        out_stall  <= 1'b1;
        stall_hold <= $urandom_range(0, 3);
      end else begin
        out_stall  <= 1'b1;
        stall_hold <= $urandom_range(10, 40);
      end
    end
  end

  // ---------------- stimulus ----------------

  function automatic int pick_gap();
    int roll;
    if (!send_gaps_on) return 0;
    roll = $urandom_range(0, 99);
    if (roll < 55) return 0;
    if (roll < 92) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  task automatic send_angles(input int roll, input int pitch, input int yaw);
    in_t beat;
    int gap;
    beat.roll_angle  = roll[15:0];
    beat.pitch_angle = pitch[15:0];
    beat.yaw_angle   = yaw[15:0];
    gap = pick_gap();
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= beat;
    do @(posedge clk); while (in_stall !== 1'b0);
    expected_quat_q.push_back(predict_quat(beat));
    sent_count++;
  endtask

  task automatic wait_drained();
    in_valid <= 1'b0;
    do @(posedge clk); while (expected_quat_q.size() != 0);
  endtask

  function automatic int near_axis();
    int base;
    case ($urandom_range(0, 4))
      0: base = 0;
      1: base = 16384;
      2: base = -16384;
      3: base = -32768;
      default: base = 32767;
    endcase
    return base + $urandom_range(0, 64) - 32;
  endfunction

  task automatic test_corner_angles();
    send_angles(0, 0, 0);
    send_angles(-32768, -32768, -32768);   // -pi on every axis
    send_angles(32767, 32767, 32767);
    send_angles(-32768, 0, 0);
    send_angles(0, -32768, 0);
    send_angles(0, 0, -32768);
    send_angles(16384, 0, 0);
    send_angles(0, 16384, 0);              // gimbal lock
    send_angles(0, -16384, 0);
    send_angles(0, 0, 16384);
    send_angles(16384, 16384, 16384);
    send_angles(-16384, -16384, -16384);
    send_angles(1, -1, 1);
    send_angles(-1, 1, -1);
    send_angles(21845, -21846, 21845);     // alternating bit patterns
    send_angles(-21846, 21845, -21846);
    send_angles(32767, -32768, 0);
    send_angles(-32768, 32767, 16384);
    send_angles(8192, -8192, 24576);
    send_angles(0, 32767, -32768);
    send_angles(2, 0, -2);
  endtask

  task automatic test_full_range(input int count);
    repeat (count)
      send_angles($urandom_range(0, 65535), $urandom_range(0, 65535),
                  $urandom_range(0, 65535));
  endtask

  // angles near zero, quarter and half turns, where components sit near zero or saturate
  task automatic test_near_axes(input int count);
    repeat (count)
      send_angles(near_axis(), near_axis(), near_axis());
  endtask

  task automatic test_drain_between_bursts(input int bursts);
    repeat (bursts) begin
      repeat ($urandom_range(1, 12))
        send_angles($urandom_range(0, 65535), near_axis(), $urandom_range(0, 65535));
      wait_drained();
    end
  endtask

  task automatic test_streaming(input int count);
    send_gaps_on = 1'b0;
    stall_on     = 1'b0;
    test_full_range(count);
    send_gaps_on = 1'b1;
    stall_on     = 1'b1;
  endtask

  initial begin
    repeat (RESET_CYCLES) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_corner_angles();
    test_full_range(380);
    test_near_axes(150);
    test_drain_between_bursts(12);
    test_streaming(60);
    test_full_range(40);

    wait_drained();
    repeat (LATENCY + 16) @(posedge clk);

    $display("covered %0d attitude beats (corners, full range, near-axis, bursts, streaming)",
             sent_count);
    $display("%0d quaternion beats checked, %0d mismatches", checked_count, mismatch_count);
    if (mismatch_count == 0 && expected_quat_q.size() == 0)
      $display("euler_to_quaternion: match");
    else
      $display("euler_to_quaternion: mismatch");
    $finish;
  end

endmodule
